>>> hdl/hsv_to_rgb_pixel_defines.svh
// Assertion helpers for the checker file of this block.
`ifndef HSV_TO_RGB_PIXEL_DEFINES_SVH
`define HSV_TO_RGB_PIXEL_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define HSV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define HSV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hdl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

   // Pipeline depth in register stages.
   localparam int STAGES = 7;

   localparam int CHANNEL_BITS_DEFAULT = 8;

   // Width of a Q1.16 component.
   localparam int COMP_W = 17;

   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // One sector is 60 degrees in 1/64 degree units.
   localparam logic [16:0] SECTOR_UNITS = 17'd3840;

   // Nine sectors of bias keep the biased hue non-negative.
   localparam logic [4:0]  HUE_BIAS_SECTORS = 5'd9;
   localparam logic [17:0] HUE_BIAS = 18'd34560;

   // floor(x / 15) == (x * 2185) >> 15 for every 9-bit x.
   localparam logic [20:0] DIV15_RECIP = 21'd2185;

   // floor(rem * 65536 / 3840) == (rem * 1118482) >> 16 for rem below 3840.
   localparam logic [20:0] FRAC_RECIP = 21'd1118482;

   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // Per-pixel decisions that ride along with the arithmetic.
   typedef struct packed {
      sector_type sector;
      logic       hue_err;
      logic       v_zero;
      logic       s_zero;
   } ctx_type;

endpackage

>>> hdl/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter. Takes one pixel per clock unless stalled (hue signed in 1/64
// degree, saturation and brightness unsigned Q1.16, values above 1.0 clamp to 1.0) and
// returns red, green and blue of CHANNEL_BITS each, the same three packed as
// red-green-blue from the top, and a flag for a hue more than one sector outside
// 0..360 degrees at nonzero saturation and brightness, which also forces white. Every
// pixel passes through a seven-stage pipeline with at most one multiplier level per stage;
// a new transaction may enter on every clock, and back-pressure on the result
// side only stops the stages that are full, so empty stages keep filling.
module hsv_to_rgb_pixel #(
   parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [15:0]            req_hue,
   input  logic [16:0]                   req_saturation,
   input  logic [16:0]                   req_brightness,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CHANNEL_BITS-1:0]       rsp_red,
   output logic [CHANNEL_BITS-1:0]       rsp_green,
   output logic [CHANNEL_BITS-1:0]       rsp_blue,
   output logic [3*CHANNEL_BITS-1:0]     rsp_packed_color,
   output logic                          rsp_hue_error
);

   logic [hsv2rgb_pkg::STAGES-1:0] stage_en;
   logic [16:0]                    p_val, q_val, t_val, v_val;
   hsv2rgb_pkg::ctx_type           ctx;

   hsv2rgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stage_en  (stage_en)
   );

   hsv2rgb_front u_front (
      .clock    (clock),
      .stage_en (stage_en),
      .in_hue   (req_hue),
      .in_sat   (req_saturation),
      .in_val   (req_brightness),
      .p_out    (p_val),
      .q_out    (q_val),
      .t_out    (t_val),
      .v_out    (v_val),
      .ctx_out  (ctx)
   );

   hsv2rgb_back #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_back (
      .clock    (clock),
      .stage_en (stage_en),
      .p_in     (p_val),
      .q_in     (q_val),
      .t_in     (t_val),
      .v_in     (v_val),
      .ctx_in   (ctx),
      .red      (rsp_red),
      .green    (rsp_green),
      .blue     (rsp_blue),
      .hue_err  (rsp_hue_error)
   );

   assign rsp_packed_color = {rsp_red, rsp_green, rsp_blue};

endmodule

>>> hdl/hsv2rgb_ctrl.sv
module hsv2rgb_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hsv2rgb_pkg::STAGES-1:0]    stage_en
);

   logic [hsv2rgb_pkg::STAGES-1:0] valid_ff;
   logic [hsv2rgb_pkg::STAGES-1:0] valid_in;
   logic [hsv2rgb_pkg::STAGES:0]   ready_chain;

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      ready_chain[hsv2rgb_pkg::STAGES] = rsp_ready;
      for (int k = hsv2rgb_pkg::STAGES - 1; k >= 0; k--) begin
         ready_chain[k] = !valid_ff[k] || ready_chain[k+1];
      end
   end

   always_comb begin
      valid_in[0] = ready_chain[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < hsv2rgb_pkg::STAGES; k++) begin
         valid_in[k] = ready_chain[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = ready_chain[0];
   assign rsp_valid = valid_ff[hsv2rgb_pkg::STAGES-1];
   assign stage_en  = ready_chain[hsv2rgb_pkg::STAGES-1:0];

endmodule

>>> hdl/hsv2rgb_front.sv
module hsv2rgb_front (
   input  logic                              clock,
   input  logic [hsv2rgb_pkg::STAGES-1:0]    stage_en,
   input  logic signed [15:0]                in_hue,
   input  logic [16:0]                       in_sat,
   input  logic [16:0]                       in_val,
   output logic [16:0]                       p_out,
   output logic [16:0]                       q_out,
   output logic [16:0]                       t_out,
   output logic [16:0]                       v_out,
   output hsv2rgb_pkg::ctx_type              ctx_out
);

   // Stage 0: clamp, bias the hue and find the sector index.
   logic [16:0] s_clamp, v_clamp;
   logic [17:0] hue_biased;
   logic [16:0] u_in;
   logic [20:0] quot_prod;
   logic [4:0]  quot_in;

   logic [16:0] u_ff, s0_ff, v0_ff;
   logic [4:0]  quot_ff;
   logic        vz0_ff, sz0_ff;

   always_comb begin
      s_clamp    = (in_sat > hsv2rgb_pkg::ONE_Q16) ? hsv2rgb_pkg::ONE_Q16 : in_sat;
      v_clamp    = (in_val > hsv2rgb_pkg::ONE_Q16) ? hsv2rgb_pkg::ONE_Q16 : in_val;
      hue_biased = 18'(in_hue) + hsv2rgb_pkg::HUE_BIAS;
      u_in       = hue_biased[16:0];
      quot_prod  = 21'(u_in[16:8]) * hsv2rgb_pkg::DIV15_RECIP;
      quot_in    = quot_prod[19:15];
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u_ff    <= u_in;
         quot_ff <= quot_in;
         s0_ff   <= s_clamp;
         v0_ff   <= v_clamp;
         vz0_ff  <= (v_clamp == '0);
         sz0_ff  <= (s_clamp == '0);
      end
   end

   // Stage 1: remainder within the sector, sector decode and p.
   logic [16:0]             rem_wide;
   logic [11:0]             rem_in;
   hsv2rgb_pkg::sector_type sector_in;
   logic                    hue_err_in;
   logic [33:0]             p_prod;

   logic [11:0]          rem_ff;
   logic [16:0]          s1_ff, v1_ff, p1_ff;
   hsv2rgb_pkg::ctx_type ctx1_ff;

   always_comb begin
      rem_wide   = u_ff - 17'(quot_ff) * hsv2rgb_pkg::SECTOR_UNITS;
      rem_in     = rem_wide[11:0];
      hue_err_in = 1'b0;
      sector_in  = hsv2rgb_pkg::SEC_RED_YEL;
      if (quot_ff inside {[hsv2rgb_pkg::HUE_BIAS_SECTORS :
                           hsv2rgb_pkg::HUE_BIAS_SECTORS + 5]}) begin
         sector_in = hsv2rgb_pkg::sector_type'(3'(quot_ff - hsv2rgb_pkg::HUE_BIAS_SECTORS));
      end else if (quot_ff == hsv2rgb_pkg::HUE_BIAS_SECTORS - 5'd1) begin
         // One sector below zero wraps to magenta-red.
         sector_in = hsv2rgb_pkg::SEC_MAG_RED;
      end else if (quot_ff == hsv2rgb_pkg::HUE_BIAS_SECTORS + 5'd6) begin
         // A full turn wraps back to red-yellow.
         sector_in = hsv2rgb_pkg::SEC_RED_YEL;
      end else begin
         hue_err_in = 1'b1;
      end
      p_prod = 34'(v0_ff) * 34'(hsv2rgb_pkg::ONE_Q16 - s0_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rem_ff          <= rem_in;
         s1_ff           <= s0_ff;
         v1_ff           <= v0_ff;
         p1_ff           <= p_prod[32:16];
         ctx1_ff.sector  <= sector_in;
         ctx1_ff.hue_err <= hue_err_in;
         ctx1_ff.v_zero  <= vz0_ff;
         ctx1_ff.s_zero  <= sz0_ff;
      end
   end

   // Stage 2: fraction f within the sector, Q0.16.
   logic [32:0] f_prod;

   logic [15:0]          f_ff;
   logic [16:0]          s2_ff, v2_ff, p2_ff;
   hsv2rgb_pkg::ctx_type ctx2_ff;

   assign f_prod = 33'(rem_ff) * 33'(hsv2rgb_pkg::FRAC_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         f_ff    <= f_prod[31:16];
         s2_ff   <= s1_ff;
         v2_ff   <= v1_ff;
         p2_ff   <= p1_ff;
         ctx2_ff <= ctx1_ff;
      end
   end

   // Stage 3: s*f and s*(1-f).
   logic [33:0] sf_prod, sfc_prod;

   logic [16:0]          sf_ff, sfc_ff;
   logic [16:0]          v3_ff, p3_ff;
   hsv2rgb_pkg::ctx_type ctx3_ff;

   always_comb begin
      sf_prod  = 34'(s2_ff) * 34'(f_ff);
      sfc_prod = 34'(s2_ff) * 34'(hsv2rgb_pkg::ONE_Q16 - 17'(f_ff));
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sf_ff   <= sf_prod[32:16];
         sfc_ff  <= sfc_prod[32:16];
         v3_ff   <= v2_ff;
         p3_ff   <= p2_ff;
         ctx3_ff <= ctx2_ff;
      end
   end

   // Stage 4: q and t.
   logic [33:0] q_prod, t_prod;

   logic [16:0]          q_ff, t_ff, v4_ff, p4_ff;
   hsv2rgb_pkg::ctx_type ctx4_ff;

   always_comb begin
      q_prod = 34'(v3_ff) * 34'(hsv2rgb_pkg::ONE_Q16 - sf_ff);
      t_prod = 34'(v3_ff) * 34'(hsv2rgb_pkg::ONE_Q16 - sfc_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         q_ff    <= q_prod[32:16];
         t_ff    <= t_prod[32:16];
         v4_ff   <= v3_ff;
         p4_ff   <= p3_ff;
         ctx4_ff <= ctx3_ff;
      end
   end

   assign p_out   = p4_ff;
   assign q_out   = q_ff;
   assign t_out   = t_ff;
   assign v_out   = v4_ff;
   assign ctx_out = ctx4_ff;

endmodule

>>> hdl/hsv2rgb_back.sv
module hsv2rgb_back #(
   parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic [hsv2rgb_pkg::STAGES-1:0]    stage_en,
   input  logic [16:0]                       p_in,
   input  logic [16:0]                       q_in,
   input  logic [16:0]                       t_in,
   input  logic [16:0]                       v_in,
   input  hsv2rgb_pkg::ctx_type              ctx_in,
   output logic [CHANNEL_BITS-1:0]           red,
   output logic [CHANNEL_BITS-1:0]           green,
   output logic [CHANNEL_BITS-1:0]           blue,
   output logic                              hue_err
);

   localparam int WIDE_W = hsv2rgb_pkg::COMP_W + CHANNEL_BITS;

   // Stage 5: pick the components for the sector and the special cases.
   logic [16:0] r_sel, g_sel, b_sel;
   logic        err_sel;

   logic [16:0] r_ff, g_ff, b_ff;
   logic        err5_ff;

   always_comb begin
      r_sel   = v_in;
      g_sel   = v_in;
      b_sel   = v_in;
      err_sel = 1'b0;
      if (ctx_in.v_zero) begin
         r_sel = '0;
         g_sel = '0;
         b_sel = '0;
      end else if (ctx_in.s_zero) begin
         r_sel = v_in;
         g_sel = v_in;
         b_sel = v_in;
      end else if (ctx_in.hue_err) begin
         r_sel   = hsv2rgb_pkg::ONE_Q16;
         g_sel   = hsv2rgb_pkg::ONE_Q16;
         b_sel   = hsv2rgb_pkg::ONE_Q16;
         err_sel = 1'b1;
      end else begin
         case (ctx_in.sector)
            hsv2rgb_pkg::SEC_RED_YEL: begin
               r_sel = v_in; g_sel = t_in; b_sel = p_in;
            end
            hsv2rgb_pkg::SEC_YEL_GRN: begin
               r_sel = q_in; g_sel = v_in; b_sel = p_in;
            end
            hsv2rgb_pkg::SEC_GRN_CYN: begin
               r_sel = p_in; g_sel = v_in; b_sel = t_in;
            end
            hsv2rgb_pkg::SEC_CYN_BLU: begin
               r_sel = p_in; g_sel = q_in; b_sel = v_in;
            end
            hsv2rgb_pkg::SEC_BLU_MAG: begin
               r_sel = t_in; g_sel = p_in; b_sel = v_in;
            end
            hsv2rgb_pkg::SEC_MAG_RED: begin
               r_sel = v_in; g_sel = p_in; b_sel = q_in;
            end
            default: begin
               r_sel = v_in; g_sel = v_in; b_sel = v_in;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         r_ff    <= r_sel;
         g_ff    <= g_sel;
         b_ff    <= b_sel;
         err5_ff <= err_sel;
      end
   end

   // Stage 6: scale each component by 2^CHANNEL_BITS - 1 and drop 16 fraction bits.
   logic [WIDE_W-1:0] r_ext, g_ext, b_ext;
   logic [WIDE_W-1:0] r_scaled, g_scaled, b_scaled;

   logic [CHANNEL_BITS-1:0] red_ff, green_ff, blue_ff;
   logic                    err6_ff;

   always_comb begin
      r_ext    = WIDE_W'(r_ff);
      g_ext    = WIDE_W'(g_ff);
      b_ext    = WIDE_W'(b_ff);
      r_scaled = (r_ext << CHANNEL_BITS) - r_ext;
      g_scaled = (g_ext << CHANNEL_BITS) - g_ext;
      b_scaled = (b_ext << CHANNEL_BITS) - b_ext;
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         red_ff   <= r_scaled[16 +: CHANNEL_BITS];
         green_ff <= g_scaled[16 +: CHANNEL_BITS];
         blue_ff  <= b_scaled[16 +: CHANNEL_BITS];
         err6_ff  <= err5_ff;
      end
   end

   assign red     = red_ff;
   assign green   = green_ff;
   assign blue    = blue_ff;
   assign hue_err = err6_ff;

endmodule

>>> hdl/hsv2rgb_checker.sv
`include "hsv_to_rgb_pixel_defines.svh"

module hsv2rgb_checker #(
   parameter int CHANNEL_BITS = hsv2rgb_pkg::CHANNEL_BITS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [CHANNEL_BITS-1:0]       rsp_red,
   input logic [CHANNEL_BITS-1:0]       rsp_green,
   input logic [CHANNEL_BITS-1:0]       rsp_blue,
   input logic [3*CHANNEL_BITS-1:0]     rsp_packed_color,
   input logic                          rsp_hue_error
);

   logic                    rsp_stall;
   logic [3*CHANNEL_BITS:0] rsp_word;
   logic                    rsp_white;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_packed_color, rsp_hue_error};
   assign rsp_white = &{rsp_red, rsp_green, rsp_blue};

   // A stalled result transaction stays put.
   `HSV_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_word), "result not held")

   // With no result waiting, the pipeline is free and must take a pixel.
   `HSV_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "input stalled with empty output")

   // A result flagged with a hue error always comes out white.
   `HSV_ASSERT(a_err_white, rsp_valid && rsp_hue_error |-> rsp_white, "hue error without white")

   // Reset empties the pipeline.
   `HSV_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind hsv_to_rgb_pixel hsv2rgb_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_checker (.*);
